// File: rtl/ilst_pkg.sv
// Shared request codes, status codes and cell control types for the indexed list store.
package ilst_pkg;

	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_SET    = 3'd3;
	localparam logic [2:0] MODE_GET    = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] data;
	} cell_ctl_t;

endpackage

// File: rtl/indexed_list_store.sv
// Top level of the indexed list store: request decode, row of slot cells and read gather.
//
// A request is taken at a rising edge where start is high and busy is low; it carries
// mode, position and data_word. Busy is set by reset and is cleared by the clock once
// reset is released, then stays low, so a request may follow in every cycle.
// Append, insert, remove and overwrite update the row of slot cells at the edge that
// takes the request: on insert or remove every slot from the target onward changes at once.
// A read gathers the addressed slot through two registered OR levels over groups of
// eight slots: the result (read_word, list_length, status) is registered in the s1 stage
// and then in the output registers, and appears with done high for exactly one cycle.
// Results come out in request order, one per request, one per cycle at most.
// The receiver cannot stall the block and must take each result while done is high.
// Reset clears the length to zero; slot contents are not cleared and are never
// visible before they are written.
module indexed_list_store
	import ilst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic [5:0]         position,
	input  logic signed [31:0] data_word,
	output logic               done,
	output logic signed [31:0] read_word,
	output logic [6:0]         list_length,
	output logic [1:0]         status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 6) ? CW : 6;
	localparam int NR = (CAPACITY < 64) ? CAPACITY : 64;
	localparam int NG = (NR + 7) / 8;

	logic               busy_q;
	logic [CW-1:0]      count_q;
	logic               accept;
	logic               pos_ok;
	logic               full;
	cell_ctl_t          ctl;
	logic [PW-1:0]      target;
	logic [CW-1:0]      count_d;
	logic [1:0]         status_d;
	logic signed [31:0] word [CAPACITY];
	logic signed [31:0] grp_d [NG];

	logic               valid_s1;
	logic               is_get_s1;
	logic [1:0]         status_s1;
	logic [6:0]         len_s1;
	logic signed [31:0] grp_s1 [NG];
	logic signed [31:0] gather;

	logic               done_q;
	logic signed [31:0] read_word_q;
	logic [6:0]         list_length_q;
	logic [1:0]         status_q;

	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign pos_ok = PW'(position) < PW'(count_q);
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		ctl.op   = CELL_HOLD;
		ctl.data = data_word;
		target   = PW'(position);
		count_d  = count_q;
		status_d = ST_OK;
		unique case (mode)
			MODE_APPEND: begin
				target = PW'(count_q);
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op  = CELL_WRITE;
					count_d = count_q + CW'(1);
				end
			end
			MODE_INSERT: begin
				if (!pos_ok) begin
					status_d = ST_BAD_POS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op  = CELL_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			MODE_REMOVE: begin
				if (!pos_ok) begin
					status_d = ST_BAD_POS;
				end else begin
					ctl.op  = CELL_REMOVE;
					count_d = count_q - CW'(1);
				end
			end
			MODE_SET: begin
				if (!pos_ok) begin
					status_d = ST_BAD_POS;
				end else begin
					ctl.op = CELL_WRITE;
				end
			end
			MODE_GET: begin
				if (!pos_ok) begin
					status_d = ST_BAD_POS;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (!accept) begin
			ctl.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ilst_cell #(
			.IDX(i),
			.TW (PW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.target   (target),
			.prev_word((i == 0) ? word[i] : word[(i == 0) ? 0 : i - 1]),
			.next_word((i == CAPACITY - 1) ? word[i] : word[(i == CAPACITY - 1) ? i : i + 1]),
			.word     (word[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < 8; j++) begin
				if ((g * 8 + j) < NR) begin
					if (position == 6'(g * 8 + j)) begin
						grp_d[g] = grp_d[g] | word[g * 8 + j];
					end
				end
			end
		end
	end

	always_comb begin
		gather = '0;
		for (int g = 0; g < NG; g++) begin
			gather = gather | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_get_s1 <= (mode == MODE_GET);
			status_s1 <= status_d;
			len_s1    <= 7'(count_d);
			grp_s1    <= grp_d;
		end
		if (valid_s1) begin
			list_length_q <= len_s1;
			status_q      <= status_s1;
			if (!is_get_s1) begin
				read_word_q <= '0;
			end else if (status_s1 == ST_BAD_POS) begin
				read_word_q <= INT_MAX;
			end else begin
				read_word_q <= gather;
			end
		end
	end

	assign done        = done_q;
	assign read_word   = read_word_q;
	assign list_length = list_length_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("request did not produce a result two cycles later");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length beyond capacity");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (list_length == 7'(CAPACITY)))
		else $error("store full reported while list not at capacity");
`endif

endmodule

// File: rtl/ilst_cell.sv
// One slot of the list: holds a word and shifts toward either neighbor on insert or remove.
module ilst_cell
	import ilst_pkg::*;
#(
	parameter int IDX = 0,
	parameter int TW  = 7
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [TW-1:0]         target,
	input  logic signed [31:0]    prev_word,
	input  logic signed [31:0]    next_word,
	output logic signed [31:0]    word
);

	logic signed [31:0] word_q;
	logic               at_target;
	logic               past_target;

	assign at_target   = (target == TW'(IDX));
	assign past_target = (TW'(IDX) > target);
	assign word        = word_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_WRITE: begin
				if (at_target) begin
					word_q <= ctl.data;
				end
			end
			CELL_INSERT: begin
				if (at_target) begin
					word_q <= ctl.data;
				end else if (past_target) begin
					word_q <= prev_word;
				end
			end
			CELL_REMOVE: begin
				if (at_target || past_target) begin
					word_q <= next_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

endmodule
